// ===== src/ready_queue_priority_aging_macros.svh =====
// assertion macros for the ready queue block
// used by the top level only, no other dependencies
`ifndef READY_QUEUE_PRIORITY_AGING_MACROS_SVH
`define READY_QUEUE_PRIORITY_AGING_MACROS_SVH

// same-cycle implication, reset masks the check
`define RQPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define RQPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rqpa_pkg.sv =====
// shared types, constants and field conversions for the ready queue
// no dependencies
package rqpa_pkg;

   localparam int DEPTH     = 8;
   localparam int ID_BITS   = 8;
   localparam int PRIO_BITS = 8;

   localparam int FIELD_W   = 8;
   localparam int OCC_W     = 4;
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_POP    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_AGE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_CAP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REM_RD,
      S_REM_CHK,
      S_AGE_RD,
      S_AGE_WR,
      S_POST,
      S_SORT_RD0,
      S_SORT_LD,
      S_SORT_RD,
      S_SORT_CMP,
      S_HEAD_RD,
      S_FINISH
   } seq_state_type;

   // result of the shared compare / increment unit
   typedef struct packed {
      logic                 less;
      logic                 id_match;
      logic [PRIO_BITS-1:0] aged_prio;
   } alu_res_type;

   function automatic logic [ID_BITS-1:0] id_from_field(input logic [FIELD_W-1:0] v);
      logic [ID_BITS-1:0] r;
      r = '0;
      for (int b = 0; b < ID_BITS && b < FIELD_W; b++) r[b] = v[b];
      return r;
   endfunction

   function automatic logic [PRIO_BITS-1:0] prio_from_field(input logic [FIELD_W-1:0] v);
      logic [PRIO_BITS-1:0] r;
      r = '0;
      for (int b = 0; b < PRIO_BITS && b < FIELD_W; b++) r[b] = v[b];
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] id_to_field(input logic [ID_BITS-1:0] v);
      logic [FIELD_W-1:0] r;
      r = '0;
      for (int b = 0; b < ID_BITS && b < FIELD_W; b++) r[b] = v[b];
      return r;
   endfunction

   function automatic logic [FIELD_W-1:0] prio_to_field(input logic [PRIO_BITS-1:0] v);
      logic [FIELD_W-1:0] r;
      r = '0;
      for (int b = 0; b < PRIO_BITS && b < FIELD_W; b++) r[b] = v[b];
      return r;
   endfunction

   function automatic logic [OCC_W-1:0] count_to_occ(input logic [CNT_BITS-1:0] v);
      logic [OCC_W-1:0] r;
      r = '0;
      for (int b = 0; b < CNT_BITS && b < OCC_W; b++) r[b] = v[b];
      return r;
   endfunction

endpackage

// ===== src/rqpa_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rqpa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rqpa_alu.sv =====
// shared compare and saturating increment unit of the ready queue
// depends on rqpa_pkg
module rqpa_alu (
   input  rqpa_pkg::entry_type            held,
   input  rqpa_pkg::entry_type            cur,
   input  logic [rqpa_pkg::ID_BITS-1:0]   key_id,
   output rqpa_pkg::alu_res_type          res
);

   // strict compare keeps equal priorities in place
   always_comb begin
      res.less      = (held.prio < cur.prio);
      res.id_match  = (cur.id == key_id);
      res.aged_prio = (cur.prio == {rqpa_pkg::PRIO_BITS{1'b1}}) ? cur.prio
                                                               : cur.prio + 1'b1;
   end

endmodule

// ===== src/ready_queue_priority_aging.sv =====
// Ready queue of up to DEPTH (id, priority) entries held in a small ram, worked
// by one sequencer around a shared compare / increment unit. One request is in
// work at a time: req_stall is low only while the sequencer is idle, and a
// finished result waits in an output register so the next request can start.
// In priority order each successful insert, pop or remove adds a bubble sort,
// one pass after another until a pass makes no swap, the single ram read
// port setting the pace. csr_ready is always high; fifo_order should be
// changed only while idle, and the block itself does not enforce it.
// depends on rqpa_pkg, rqpa_ram, rqpa_alu and the assertion macro header
`include "ready_queue_priority_aging_macros.svh"

module ready_queue_priority_aging (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_fifo_order,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_entry_id,
   input  logic [7:0] req_entry_priority,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_popped_id,
   output logic [7:0] rsp_popped_priority,
   output logic [3:0] rsp_occupancy,
   output logic       rsp_head_valid,
   output logic [7:0] rsp_head_id
);

   localparam int CW = rqpa_pkg::CNT_BITS;
   localparam int AW = rqpa_pkg::ADDR_BITS;

   // control and payload registers
   rqpa_pkg::seq_state_type    state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              idx_ff, idx_in;
   logic                       swap_ff, swap_in;
   logic                       fifo_order_ff;
   rqpa_pkg::op_type           mode_ff, mode_in;
   rqpa_pkg::entry_type        key_ff, key_in;
   rqpa_pkg::entry_type        held_ff, held_in;
   rqpa_pkg::status_type       status_ff, status_in;
   rqpa_pkg::entry_type        popped_ff, popped_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   rqpa_pkg::status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]                 rsp_pid_ff, rsp_pid_in;
   logic [7:0]                 rsp_ppr_ff, rsp_ppr_in;
   logic [3:0]                 rsp_occ_ff, rsp_occ_in;
   logic                       rsp_hv_ff, rsp_hv_in;
   logic [7:0]                 rsp_hid_ff, rsp_hid_in;

   // ram and shared unit wiring
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   rqpa_pkg::entry_type        wr_data, rd_data;
   rqpa_pkg::alu_res_type      alu_res;

   logic                       req_accept, rsp_take, out_free;
   logic [CW-1:0]              idx_p1, idx_m1, cnt_m1;

   rqpa_ram #(
      .WIDTH (rqpa_pkg::ENTRY_W),
      .DEPTH (rqpa_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rqpa_alu u_alu (
      .held   (held_ff),
      .cur    (rd_data),
      .key_id (key_ff.id),
      .res    (alu_res)
   );

   // handshakes
   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != rqpa_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign idx_p1 = idx_ff + 1'b1;
   assign idx_m1 = idx_ff - 1'b1;
   assign cnt_m1 = count_ff - 1'b1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_order_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         fifo_order_ff <= csr_fifo_order;
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqpa_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      swap_ff       <= swap_in;
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      held_ff       <= held_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_ppr_ff    <= rsp_ppr_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_hv_ff     <= rsp_hv_in;
      rsp_hid_ff    <= rsp_hid_in;
   end

   // sequencer: next state, ram control and result capture
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      swap_in       = swap_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      held_in       = held_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_take;
      rsp_status_in = rsp_status_ff;
      rsp_pid_in    = rsp_pid_ff;
      rsp_ppr_in    = rsp_ppr_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_hv_in     = rsp_hv_ff;
      rsp_hid_in    = rsp_hid_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AW-1:0];
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];

      unique case (state_ff)
         rqpa_pkg::S_IDLE: begin
            if (req_accept) begin
               mode_in      = rqpa_pkg::op_type'(req_mode);
               key_in.id    = rqpa_pkg::id_from_field(req_entry_id);
               key_in.prio  = rqpa_pkg::prio_from_field(req_entry_priority);
               status_in    = rqpa_pkg::ST_OK;
               popped_in    = '0;
               idx_in       = '0;
               unique case (rqpa_pkg::op_type'(req_mode))
                  rqpa_pkg::OP_INSERT: begin
                     if (count_ff == CW'(rqpa_pkg::DEPTH)) begin
                        status_in = rqpa_pkg::ST_FULL;
                        state_in  = rqpa_pkg::S_HEAD_RD;
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = count_ff[AW-1:0];
                        wr_data.id   = rqpa_pkg::id_from_field(req_entry_id);
                        wr_data.prio = rqpa_pkg::prio_from_field(req_entry_priority);
                        count_in     = count_ff + 1'b1;
                        state_in     = rqpa_pkg::S_POST;
                     end
                  end
                  rqpa_pkg::OP_POP: begin
                     if (count_ff == '0) begin
                        status_in = rqpa_pkg::ST_EMPTY;
                        state_in  = rqpa_pkg::S_HEAD_RD;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        state_in = rqpa_pkg::S_POP_CAP;
                     end
                  end
                  rqpa_pkg::OP_REMOVE: begin
                     status_in = rqpa_pkg::ST_NOT_FOUND;
                     state_in  = rqpa_pkg::S_REM_RD;
                  end
                  rqpa_pkg::OP_AGE: begin
                     state_in = rqpa_pkg::S_AGE_RD;
                  end
                  default: state_in = rqpa_pkg::S_IDLE;
               endcase
            end
         end

         // head entry leaves, gap at slot zero
         rqpa_pkg::S_POP_CAP: begin
            popped_in = rd_data;
            idx_in    = '0;
            state_in  = rqpa_pkg::S_SHIFT_RD;
         end

         // close up entries behind the gap at idx
         rqpa_pkg::S_SHIFT_RD: begin
            if (idx_p1 < count_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_p1[AW-1:0];
               state_in = rqpa_pkg::S_SHIFT_WR;
            end else begin
               count_in = cnt_m1;
               state_in = rqpa_pkg::S_POST;
            end
         end

         rqpa_pkg::S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            idx_in   = idx_p1;
            state_in = rqpa_pkg::S_SHIFT_RD;
         end

         // search for the first matching id
         rqpa_pkg::S_REM_RD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = rqpa_pkg::S_REM_CHK;
            end else begin
               state_in = rqpa_pkg::S_HEAD_RD;
            end
         end

         rqpa_pkg::S_REM_CHK: begin
            if (alu_res.id_match) begin
               status_in = rqpa_pkg::ST_OK;
               state_in  = rqpa_pkg::S_SHIFT_RD;
            end else begin
               idx_in   = idx_p1;
               state_in = rqpa_pkg::S_REM_RD;
            end
         end

         // saturating age of every waiting entry
         rqpa_pkg::S_AGE_RD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = rqpa_pkg::S_AGE_WR;
            end else begin
               state_in = rqpa_pkg::S_HEAD_RD;
            end
         end

         rqpa_pkg::S_AGE_WR: begin
            wr_en        = 1'b1;
            wr_data.id   = rd_data.id;
            wr_data.prio = alu_res.aged_prio;
            idx_in       = idx_p1;
            state_in     = rqpa_pkg::S_AGE_RD;
         end

         // re-sort after a change in priority order
         rqpa_pkg::S_POST: begin
            if (!fifo_order_ff && (count_ff > CW'(1))) begin
               state_in = rqpa_pkg::S_SORT_RD0;
            end else begin
               state_in = rqpa_pkg::S_HEAD_RD;
            end
         end

         // bubble pass: held entry sinks while a higher priority follows
         rqpa_pkg::S_SORT_RD0: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            swap_in  = 1'b0;
            idx_in   = CW'(1);
            state_in = rqpa_pkg::S_SORT_LD;
         end

         rqpa_pkg::S_SORT_LD: begin
            held_in  = rd_data;
            state_in = rqpa_pkg::S_SORT_RD;
         end

         rqpa_pkg::S_SORT_RD: begin
            if (idx_ff < count_ff) begin
               rd_en    = 1'b1;
               state_in = rqpa_pkg::S_SORT_CMP;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cnt_m1[AW-1:0];
               wr_data  = held_ff;
               state_in = swap_ff ? rqpa_pkg::S_SORT_RD0 : rqpa_pkg::S_HEAD_RD;
            end
         end

         rqpa_pkg::S_SORT_CMP: begin
            wr_en   = 1'b1;
            wr_addr = idx_m1[AW-1:0];
            if (alu_res.less) begin
               wr_data = rd_data;
               swap_in = 1'b1;
            end else begin
               wr_data = held_ff;
               held_in = rd_data;
            end
            idx_in   = idx_p1;
            state_in = rqpa_pkg::S_SORT_RD;
         end

         // fetch the head for the result
         rqpa_pkg::S_HEAD_RD: begin
            rd_en    = (count_ff != '0);
            rd_addr  = '0;
            state_in = rqpa_pkg::S_FINISH;
         end

         // wait for the output register, then load it
         rqpa_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pid_in    = rqpa_pkg::id_to_field(popped_ff.id);
               rsp_ppr_in    = rqpa_pkg::prio_to_field(popped_ff.prio);
               rsp_occ_in    = rqpa_pkg::count_to_occ(count_ff);
               rsp_hv_in     = (count_ff != '0);
               rsp_hid_in    = (count_ff != '0) ? rqpa_pkg::id_to_field(rd_data.id) : '0;
               state_in      = rqpa_pkg::S_IDLE;
            end
         end

         default: state_in = rqpa_pkg::S_IDLE;
      endcase
   end

   // result ports
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_popped_id       = rsp_pid_ff;
   assign rsp_popped_priority = rsp_ppr_ff;
   assign rsp_occupancy       = rsp_occ_ff;
   assign rsp_head_valid      = rsp_hv_ff;
   assign rsp_head_id         = rsp_hid_ff;

   // checks on the sequencer
   `RQPA_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= CW'(rqpa_pkg::DEPTH), "entry count beyond depth")
   `RQPA_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_accept, state_ff != rqpa_pkg::S_IDLE, "request accepted but sequencer stayed idle")
   `RQPA_ASSERT_NXT(a_finish_waits, clock, reset, (state_ff == rqpa_pkg::S_FINISH) && rsp_valid_ff && rsp_stall, (state_ff == rqpa_pkg::S_FINISH) && rsp_valid_ff, "result overwrote a waiting result")
   `RQPA_ASSERT_IMP(a_full_has_head, clock, reset, rsp_valid_ff && (rsp_status_ff == rqpa_pkg::ST_FULL), rsp_hv_ff, "full status without a head entry")

endmodule
